// ----- sv/sprc_pkg.sv -----
// Shared types, constants and helpers for the step peak refractory counter.
package sprc_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned MAG_W    = 32;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned THRESH_W = 15;
   localparam int unsigned WEIGHT_W = 2;
   localparam int unsigned MET_W    = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   // count * 5000 fits in 45 bits for any 32-bit count
   localparam int unsigned PROD_W   = 45;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(300);
   localparam logic [PROD_W-1:0]   RATE_STEP    = PROD_W'(5000);
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

   // Register word index (byte address bit 2)
   localparam logic REG_TIME_THRESHOLD = 1'b0;

   typedef enum logic {
      OP_PEAK    = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   typedef enum logic [WEIGHT_W-1:0] {
      WEIGHT_SLOW  = 2'd0,
      WEIGHT_EQUAL = 2'd1,
      WEIGHT_FAST  = 2'd2
   } weight_type;

   localparam logic [MET_W-1:0] MET_REST     = MET_W'(2);
   localparam logic [MET_W-1:0] MET_LIGHT    = MET_W'(4);
   localparam logic [MET_W-1:0] MET_MODERATE = MET_W'(9);
   localparam logic [MET_W-1:0] MET_BRISK    = MET_W'(12);
   localparam logic [MET_W-1:0] MET_HARD     = MET_W'(17);
   localparam logic [MET_W-1:0] MET_MAX      = MET_W'(23);

   function automatic logic [MET_W-1:0] met_of(input logic [MAG_W-1:0] m);
      logic [MET_W-1:0] r;
      if (m < MAG_W'(5)) begin
         r = MET_REST;
      end else if (m < MAG_W'(10)) begin
         r = MET_LIGHT;
      end else if (m < MAG_W'(15)) begin
         r = MET_MODERATE;
      end else if (m < MAG_W'(20)) begin
         r = MET_BRISK;
      end else if (m < MAG_W'(25)) begin
         r = MET_HARD;
      end else begin
         r = MET_MAX;
      end
      return r;
   endfunction

endpackage

// ----- sv/sprc_if.sv -----
// Valid/ready channel interfaces for peak candidates and step results.
interface sprc_req_if;
   import sprc_pkg::*;
   logic               valid;
   logic               ready;
   logic               op;
   logic [TIME_W-1:0]  sample_time;
   logic [MAG_W-1:0]   magnitude;
   logic [MAG_W-1:0]   raw_magnitude;

   modport source (output valid, op, sample_time, magnitude, raw_magnitude,
                   input ready);
   modport sink   (input valid, op, sample_time, magnitude, raw_magnitude,
                   output ready);
endinterface

interface sprc_rsp_if;
   import sprc_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] step_count;
   logic [TIME_W-1:0]  step_time;
   logic [TIME_W-1:0]  peak_interval;
   logic [WEIGHT_W-1:0] weight_class;
   logic [MET_W-1:0]   met_value;

   modport source (output valid, step_count, step_time, peak_interval,
                   weight_class, met_value, input ready);
   modport sink   (input valid, step_count, step_time, peak_interval,
                   weight_class, met_value, output ready);
endinterface

// ----- sv/step_peak_refractory_counter_top.sv -----
// Top level of the step peak refractory counter.
//
// Usage:
//   req (sink)  : one beat per peak candidate or restart command. op selects
//                 a candidate or a restart; a restart clears the held peak and
//                 the step count and yields no result.
//   rsp (source): one beat per counted step with count, timestamp, interval
//                 since the held peak, walking-rate weight class and MET.
//   csr_*       : APB-style port, one register (time_threshold) at byte 0.
//                 Write only while the block is idle.
// Path: a candidate is captured in the input register at its req beat,
//   evaluated there against the held peak, and its result is loaded into
//   the output register, which drives rsp.
// Throughput: one beat per cycle while no step result waits on a stalled rsp;
//   back-to-back candidates see each other's held-peak update.
// Reset: held peak, step count, both pipeline valids clear; time_threshold
//   returns to 300 ms.
// Stall: while rsp is stalled a result stays in the output register; the
//   input stage keeps draining items that produce no step, and holds (with
//   req.ready low) only an item that would produce a step.
module step_peak_refractory_counter_top (
   input  logic                              clock,
   input  logic                              reset,
   sprc_req_if.sink                          req,
   sprc_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sprc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sprc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sprc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import sprc_pkg::*;

   // Configuration
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                csr_wr;

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_op_ff;
   logic [TIME_W-1:0]   s1_time_ff;
   logic [MAG_W-1:0]    s1_mag_ff;
   logic [MAG_W-1:0]    s1_omag_ff;

   // Held peak state; prod tracks steps * 5000 so no multiplier is needed
   logic [TIME_W-1:0]   held_time_ff, held_time_in;
   logic [MAG_W-1:0]    held_mag_ff, held_mag_in;
   logic [COUNT_W-1:0]  steps_ff, steps_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [TIME_W-1:0]   rsp_time_ff;
   logic [TIME_W-1:0]   rsp_interval_ff;
   weight_type          rsp_weight_ff;
   logic [MET_W-1:0]    rsp_met_ff;

   // Evaluation
   logic                req_beat;
   logic                out_free;
   logic                s1_adv;
   logic                held_empty;
   logic [TIME_W-1:0]   diff;
   logic                step_hit;
   logic                emit;
   logic [COUNT_W-1:0]  steps_next;
   logic [PROD_W-1:0]   prod_next;
   logic [PROD_W-1:0]   time_x8;
   weight_type          weight;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_wr && (csr_paddr[2] == REG_TIME_THRESHOLD)) begin
         thresh_in = csr_pwdata[THRESH_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_TIME_THRESHOLD) begin
         csr_prdata = CSR_DATA_W'(thresh_ff);
      end
   end

   // ---------------- evaluation of the captured item ----------------
   assign held_empty = (held_time_ff == '0);
   assign diff       = s1_time_ff - held_time_ff;
   // signed gap above threshold: non-negative and magnitude above it
   assign step_hit   = !held_empty && !diff[TIME_W-1] &&
                       (diff[TIME_W-2:0] > (TIME_W-1)'(thresh_ff));
   assign emit       = s1_valid_ff && (op_type'(s1_op_ff) == OP_PEAK) && step_hit;

   // saturate the count; the product follows the count exactly
   always_comb begin
      if (steps_ff == COUNT_MAX) begin
         steps_next = steps_ff;
         prod_next  = prod_ff;
      end else begin
         steps_next = steps_ff + COUNT_W'(1);
         prod_next  = prod_ff + RATE_STEP;
      end
   end

   assign time_x8 = PROD_W'({s1_time_ff, 3'b000});

   always_comb begin
      if (prod_next < time_x8) begin
         weight = WEIGHT_SLOW;
      end else if (prod_next == time_x8) begin
         weight = WEIGHT_EQUAL;
      end else begin
         weight = WEIGHT_FAST;
      end
   end

   // ---------------- handshake ----------------
   assign out_free  = !rsp_valid_ff || rsp.ready;
   // advance unless a step result would have nowhere to go
   assign s1_adv    = s1_valid_ff && (!emit || out_free);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_beat  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- held peak update ----------------
   always_comb begin
      held_time_in = held_time_ff;
      held_mag_in  = held_mag_ff;
      steps_in     = steps_ff;
      prod_in      = prod_ff;
      if (s1_adv) begin
         priority if (op_type'(s1_op_ff) == OP_RESTART) begin
            held_time_in = '0;
            held_mag_in  = '0;
            steps_in     = '0;
            prod_in      = '0;
         end else if (held_empty) begin
            held_time_in = s1_time_ff;
            held_mag_in  = s1_mag_ff;
         end else if (step_hit) begin
            held_time_in = s1_time_ff;
            held_mag_in  = s1_mag_ff;
            steps_in     = steps_next;
            prod_in      = prod_next;
         end else if (s1_mag_ff > held_mag_ff) begin
            held_time_in = s1_time_ff;
            held_mag_in  = s1_mag_ff;
         end else begin
            // equal or smaller peak inside the window: keep the held one
            held_time_in = held_time_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_time_ff <= '0;
         held_mag_ff  <= '0;
         steps_ff     <= '0;
         prod_ff      <= '0;
      end else begin
         thresh_ff    <= thresh_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         held_time_ff <= held_time_in;
         held_mag_ff  <= held_mag_in;
         steps_ff     <= steps_in;
         prod_ff      <= prod_in;
      end
   end

   // payload: capture on a beat, hold otherwise
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_op_ff   <= req.op;
         s1_time_ff <= req.sample_time;
         s1_mag_ff  <= req.magnitude;
         s1_omag_ff <= req.raw_magnitude;
      end
      if (s1_adv && emit) begin
         rsp_count_ff    <= steps_next;
         rsp_time_ff     <= s1_time_ff;
         rsp_interval_ff <= diff;
         rsp_weight_ff   <= weight;
         rsp_met_ff      <= met_of(s1_omag_ff);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.step_count    = rsp_count_ff;
   assign rsp.step_time     = rsp_time_ff;
   assign rsp.peak_interval = rsp_interval_ff;
   assign rsp.weight_class  = rsp_weight_ff;
   assign rsp.met_value     = rsp_met_ff;

   // ---------------- assertions ----------------
   // the running product must always equal count * 5000
   a_prod_tracks: assert property (@(posedge clock) disable iff (reset)
      prod_ff == (PROD_W'(steps_ff) * RATE_STEP))
      else $error("rate product out of step with count");

   // a restart leaves the count at zero
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (op_type'(s1_op_ff) == OP_RESTART)) |=> (steps_ff == '0))
      else $error("restart did not clear count");

   // every reported step counts at least one
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0))
      else $error("result with zero step count");

   // a captured item held back must only be one that produces a step
   a_stall_only_on_step: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> (emit && rsp_valid_ff && !rsp.ready))
      else $error("input stage stalled without cause");

endmodule
